FILE: sv/lbm_d2q9_thermal_bgk_collision_assert.svh
// assertion macros shared by the collision block rtl
// expects clk and rst_n in the scope of the module that uses them
`ifndef LBM_D2Q9_THERMAL_BGK_COLLISION_ASSERT_SVH
`define LBM_D2Q9_THERMAL_BGK_COLLISION_ASSERT_SVH

// same-cycle implication, off during reset
`define LBMTC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define LBMTC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lbmtc_pkg.sv
// shared types, constants and fixed-point helpers for the d2q9 thermal collision block
// no dependencies
`default_nettype none

package lbmtc_pkg;

    localparam int QW   = 32;
    localparam int FRAC = 28;
    localparam int PW   = 2 * QW;
    localparam int XW   = QW + 8;
    localparam int WW   = 27;
    localparam int DW   = 4;
    localparam int IW   = 4;

    typedef logic signed [QW-1:0] q_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [XW-1:0] ext_t;
    typedef logic signed [1:0]    comp_t;
    typedef logic [WW-1:0]        weight_t;
    typedef logic [QW-2:0]        rate_t;

    // register indexes
    localparam logic [IW-1:0] REG_INV_TAU_FLOW     = IW'(0);
    localparam logic [IW-1:0] REG_INV_TAU_HEAT     = IW'(1);
    localparam logic [IW-1:0] REG_FORCE_PREFACTOR  = IW'(2);
    localparam logic [IW-1:0] REG_SOURCE_PREFACTOR = IW'(3);

    // lattice directions
    localparam logic [DW-1:0] DIR_REST = DW'(0);
    localparam logic [DW-1:0] DIR_E    = DW'(1);
    localparam logic [DW-1:0] DIR_N    = DW'(2);
    localparam logic [DW-1:0] DIR_W    = DW'(3);
    localparam logic [DW-1:0] DIR_S    = DW'(4);
    localparam logic [DW-1:0] DIR_NE   = DW'(5);
    localparam logic [DW-1:0] DIR_NW   = DW'(6);
    localparam logic [DW-1:0] DIR_SW   = DW'(7);
    localparam logic [DW-1:0] DIR_SE   = DW'(8);

    // lattice weights, unsigned 27-bit with 28 fraction bits (scale 2^-28)
    localparam weight_t W_REST = WW'(119304647);
    localparam weight_t W_AXIS = WW'(29826162);
    localparam weight_t W_DIAG = WW'(7456540);

    localparam rate_t INV_TAU_RST   = rate_t'(466844270);
    localparam q_t    PREFACTOR_RST = q_t'(35013325);

    localparam ext_t  Q_ONE_X  = ext_t'(1) <<< FRAC;
    localparam prod_t Q_HALF_P = prod_t'(1) <<< (FRAC - 1);
    localparam ext_t  X_MAX    = (ext_t'(1) <<< (QW - 1)) - ext_t'(1);
    localparam ext_t  X_MIN    = -(ext_t'(1) <<< (QW - 1));

    typedef struct packed {
        logic [DW-1:0] direction;
        q_t            flow_in;
        q_t            heat_in;
        q_t            density;
        q_t            vel_x;
        q_t            vel_y;
        q_t            temperature;
        q_t            force_x;
        q_t            force_y;
        q_t            heat_source;
    } lbmtc_in_t;

    typedef struct packed {
        q_t flow_out;
        q_t heat_out;
    } lbmtc_out_t;

    typedef struct packed {
        rate_t inv_tau_flow;
        rate_t inv_tau_heat;
        q_t    force_prefactor;
        q_t    source_prefactor;
    } lbmtc_cfg_t;

    // hand-over from the moment stages to the relaxation stages
    typedef struct packed {
        q_t    poly;
        q_t    wrho;
        q_t    wtmp;
        prod_t ptx;
        prod_t pty;
        prod_t psr;
        q_t    fin;
        q_t    gin;
        q_t    fx;
        q_t    fy;
        q_t    qs;
    } lbmtc_mid_t;

    function automatic q_t q_sat(input ext_t v);
        q_t r;
        if (v > X_MAX)
        begin
            r = {1'b0, {(QW-1){1'b1}}};
        end
        else if (v < X_MIN)
        begin
            r = {1'b1, {(QW-1){1'b0}}};
        end
        else
        begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic ext_t q_x(input q_t a);
        return ext_t'(a);
    endfunction

    // round half up, drop fraction bits, saturate
    function automatic q_t q_round(input prod_t p);
        prod_t s;
        ext_t  t;
        s = p + Q_HALF_P;
        t = ext_t'($signed(s[PW-1:FRAC]));
        return q_sat(t);
    endfunction

    function automatic prod_t w_p(input weight_t w);
        return prod_t'({1'b0, w});
    endfunction

    function automatic ext_t lat_term(input comp_t e, input ext_t v);
        ext_t r;
        case (e)
            2'b01:   r = v;
            2'b11:   r = -v;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic comp_t lat_x(input logic [DW-1:0] d);
        comp_t r;
        unique case (d) inside
            DIR_E, DIR_NE, DIR_SE: r = 2'sb01;
            DIR_W, DIR_NW, DIR_SW: r = 2'sb11;
            default:               r = 2'sb00;
        endcase
        return r;
    endfunction

    function automatic comp_t lat_y(input logic [DW-1:0] d);
        comp_t r;
        unique case (d) inside
            DIR_N, DIR_NE, DIR_NW: r = 2'sb01;
            DIR_S, DIR_SW, DIR_SE: r = 2'sb11;
            default:               r = 2'sb00;
        endcase
        return r;
    endfunction

    function automatic weight_t lat_w(input logic [DW-1:0] d);
        weight_t r;
        unique case (d) inside
            DIR_REST:                      r = W_REST;
            DIR_E, DIR_N, DIR_W, DIR_S:    r = W_AXIS;
            DIR_NE, DIR_NW, DIR_SW, DIR_SE: r = W_DIAG;
            default:                       r = '0;
        endcase
        return r;
    endfunction

    // times 4.5 in q3.28 with half-up rounding: (9z + 1) >> 1
    function automatic q_t q_mul_4p5(input q_t z);
        ext_t t;
        t = (q_x(z) <<< 3) + q_x(z) + ext_t'(1);
        return q_sat(t >>> 1);
    endfunction

    // times 1.5 in q3.28 with half-up rounding: (3z + 1) >> 1
    function automatic q_t q_mul_1p5(input q_t z);
        ext_t t;
        t = (q_x(z) <<< 1) + q_x(z) + ext_t'(1);
        return q_sat(t >>> 1);
    endfunction

endpackage

`default_nettype wire

FILE: sv/lbmtc_cfg_regs.sv
// relaxation and prefactor registers with their write port
// depends on lbmtc_pkg and the assertion macro header
`default_nettype none
`include "lbm_d2q9_thermal_bgk_collision_assert.svh"

module lbmtc_cfg_regs import lbmtc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [IW-1:0] cfg_index,
    input  wire q_t            cfg_data,
    output lbmtc_cfg_t         cfg
);

    lbmtc_cfg_t cfg_reg;
    lbmtc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_INV_TAU_FLOW:     cfg_next.inv_tau_flow     = cfg_data[QW-2:0];
                REG_INV_TAU_HEAT:     cfg_next.inv_tau_heat     = cfg_data[QW-2:0];
                REG_FORCE_PREFACTOR:  cfg_next.force_prefactor  = cfg_data;
                REG_SOURCE_PREFACTOR: cfg_next.source_prefactor = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inv_tau_flow     <= INV_TAU_RST;
            cfg_reg.inv_tau_heat     <= INV_TAU_RST;
            cfg_reg.force_prefactor  <= PREFACTOR_RST;
            cfg_reg.source_prefactor <= PREFACTOR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    `LBMTC_ASSERT_NXT(a_flow_rate_write, cfg_valid && cfg_ready && cfg_index == REG_INV_TAU_FLOW, cfg.inv_tau_flow == $past(cfg_data[QW-2:0]), "flow rate write lost")
    `LBMTC_ASSERT_NXT(a_cfg_hold, !(cfg_valid && cfg_ready), $stable(cfg), "registers moved without a write")
    `LBMTC_ASSERT_NXT(a_cfg_bad_index, cfg_valid && cfg_index != REG_INV_TAU_FLOW && cfg_index != REG_INV_TAU_HEAT && cfg_index != REG_FORCE_PREFACTOR && cfg_index != REG_SOURCE_PREFACTOR, $stable(cfg), "write to unknown index took effect")

endmodule

`default_nettype wire

FILE: sv/lbmtc_front.sv
// first three stages: lattice decode, velocity moments, equilibrium polynomial, force terms
// depends on lbmtc_pkg and the assertion macro header
`default_nettype none
`include "lbm_d2q9_thermal_bgk_collision_assert.svh"

module lbmtc_front import lbmtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_vld,
    input  wire lbmtc_in_t  operands,
    input  wire lbmtc_cfg_t cfg,
    output logic            mid_vld,
    output lbmtc_mid_t      mid
);

    // stage a
    logic    a_vld_reg, a_vld_next;
    comp_t   a_ex_reg, a_ex_next, a_ey_reg, a_ey_next;
    q_t      a_eu_reg, a_eu_next;
    prod_t   a_pvx_reg, a_pvx_next, a_pvy_reg, a_pvy_next;
    prod_t   a_pwr_reg, a_pwr_next, a_pwt_reg, a_pwt_next;
    prod_t   a_pwf_reg, a_pwf_next, a_pws_reg, a_pws_next;
    q_t      a_vx_reg, a_vy_reg, a_fin_reg, a_gin_reg, a_rho_reg;
    q_t      a_fx_reg, a_fy_reg, a_qs_reg;
    weight_t w_a;

    // stage b
    logic    b_vld_reg;
    q_t      b_uv_reg, b_uv_next, b_eu_reg;
    prod_t   b_peu_reg, b_peu_next;
    q_t      b_tx_reg, b_tx_next, b_ty_reg, b_ty_next;
    q_t      b_wrho_reg, b_wrho_next, b_wtmp_reg, b_wtmp_next;
    q_t      b_wfp_reg, b_wfp_next, b_wsp_reg, b_wsp_next;
    q_t      b_fin_reg, b_gin_reg, b_rho_reg, b_fx_reg, b_fy_reg, b_qs_reg;
    ext_t    tx_base, ty_base, nine_eu;

    // stage c
    logic       c_vld_reg;
    lbmtc_mid_t c_reg, c_next;
    q_t         e2;
    ext_t       three_eu;

    always_comb
    begin
        a_vld_next = in_vld;
        a_ex_next  = lat_x(operands.direction);
        a_ey_next  = lat_y(operands.direction);
        w_a        = lat_w(operands.direction);
        a_eu_next  = q_sat(lat_term(a_ex_next, q_x(operands.vel_x))
                         + lat_term(a_ey_next, q_x(operands.vel_y)));
        a_pvx_next = prod_t'(operands.vel_x) * prod_t'(operands.vel_x);
        a_pvy_next = prod_t'(operands.vel_y) * prod_t'(operands.vel_y);
        a_pwr_next = w_p(w_a) * prod_t'(operands.density);
        a_pwt_next = w_p(w_a) * prod_t'(operands.temperature);
        a_pwf_next = w_p(w_a) * prod_t'(cfg.force_prefactor);
        a_pws_next = w_p(w_a) * prod_t'(cfg.source_prefactor);
    end

    always_comb
    begin
        b_uv_next   = q_sat(q_x(q_round(a_pvx_reg)) + q_x(q_round(a_pvy_reg)));
        b_peu_next  = prod_t'(a_eu_reg) * prod_t'(a_eu_reg);
        nine_eu     = (q_x(a_eu_reg) <<< 3) + q_x(a_eu_reg);
        tx_base     = lat_term(a_ex_reg, Q_ONE_X) - q_x(a_vx_reg);
        ty_base     = lat_term(a_ey_reg, Q_ONE_X) - q_x(a_vy_reg);
        b_tx_next   = q_sat((tx_base <<< 1) + tx_base + lat_term(a_ex_reg, nine_eu));
        b_ty_next   = q_sat((ty_base <<< 1) + ty_base + lat_term(a_ey_reg, nine_eu));
        b_wrho_next = q_round(a_pwr_reg);
        b_wtmp_next = q_round(a_pwt_reg);
        b_wfp_next  = q_round(a_pwf_reg);
        b_wsp_next  = q_round(a_pws_reg);
    end

    always_comb
    begin
        e2          = q_round(b_peu_reg);
        three_eu    = (q_x(b_eu_reg) <<< 1) + q_x(b_eu_reg);
        c_next.poly = q_sat(Q_ONE_X + three_eu + q_x(q_mul_4p5(e2))
                          - q_x(q_mul_1p5(b_uv_reg)));
        c_next.wrho = b_wrho_reg;
        c_next.wtmp = b_wtmp_reg;
        c_next.ptx  = prod_t'(b_wfp_reg) * prod_t'(b_tx_reg);
        c_next.pty  = prod_t'(b_wfp_reg) * prod_t'(b_ty_reg);
        c_next.psr  = prod_t'(b_wsp_reg) * prod_t'(b_rho_reg);
        c_next.fin  = b_fin_reg;
        c_next.gin  = b_gin_reg;
        c_next.fx   = b_fx_reg;
        c_next.fy   = b_fy_reg;
        c_next.qs   = b_qs_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_ex_reg   <= a_ex_next;
        a_ey_reg   <= a_ey_next;
        a_eu_reg   <= a_eu_next;
        a_pvx_reg  <= a_pvx_next;
        a_pvy_reg  <= a_pvy_next;
        a_pwr_reg  <= a_pwr_next;
        a_pwt_reg  <= a_pwt_next;
        a_pwf_reg  <= a_pwf_next;
        a_pws_reg  <= a_pws_next;
        a_vx_reg   <= operands.vel_x;
        a_vy_reg   <= operands.vel_y;
        a_fin_reg  <= operands.flow_in;
        a_gin_reg  <= operands.heat_in;
        a_rho_reg  <= operands.density;
        a_fx_reg   <= operands.force_x;
        a_fy_reg   <= operands.force_y;
        a_qs_reg   <= operands.heat_source;

        b_uv_reg   <= b_uv_next;
        b_eu_reg   <= a_eu_reg;
        b_peu_reg  <= b_peu_next;
        b_tx_reg   <= b_tx_next;
        b_ty_reg   <= b_ty_next;
        b_wrho_reg <= b_wrho_next;
        b_wtmp_reg <= b_wtmp_next;
        b_wfp_reg  <= b_wfp_next;
        b_wsp_reg  <= b_wsp_next;
        b_fin_reg  <= a_fin_reg;
        b_gin_reg  <= a_gin_reg;
        b_rho_reg  <= a_rho_reg;
        b_fx_reg   <= a_fx_reg;
        b_fy_reg   <= a_fy_reg;
        b_qs_reg   <= a_qs_reg;

        c_reg      <= c_next;
    end

    assign mid_vld = c_vld_reg;
    assign mid     = c_reg;

    `LBMTC_ASSERT_IMP(a_rest_no_eu, a_vld_reg && a_ex_reg == 2'sb00 && a_ey_reg == 2'sb00, a_eu_reg == '0, "projected velocity nonzero on a null lattice vector")

endmodule

`default_nettype wire

FILE: sv/lbmtc_back.sv
// last four stages: equilibria, force and source products, relaxation, final saturating sum
// depends on lbmtc_pkg
`default_nettype none

module lbmtc_back import lbmtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       mid_vld,
    input  wire lbmtc_mid_t mid,
    input  wire lbmtc_cfg_t cfg,
    output logic            done,
    output lbmtc_out_t      result
);

    // stage d
    logic  d_vld_reg;
    prod_t d_pf_reg, d_pf_next, d_pg_reg, d_pg_next;
    q_t    d_ax_reg, d_ax_next, d_by_reg, d_by_next, d_cs_reg, d_cs_next;
    q_t    d_fin_reg, d_gin_reg, d_fx_reg, d_fy_reg, d_qs_reg;

    // stage e
    logic  e_vld_reg;
    q_t    e_df_reg, e_df_next, e_dg_reg, e_dg_next;
    prod_t e_pax_reg, e_pax_next, e_pby_reg, e_pby_next, e_pcq_reg, e_pcq_next;
    q_t    e_fin_reg, e_gin_reg;

    // stage f
    logic  f_vld_reg;
    prod_t f_pfd_reg, f_pfd_next, f_phd_reg, f_phd_next;
    q_t    f_frc_reg, f_frc_next, f_src_reg, f_src_next;
    q_t    f_fin_reg, f_gin_reg;

    // output
    logic       out_vld_reg;
    lbmtc_out_t out_reg, out_next;

    always_comb
    begin
        d_pf_next = prod_t'(mid.wrho) * prod_t'(mid.poly);
        d_pg_next = prod_t'(mid.wtmp) * prod_t'(mid.poly);
        d_ax_next = q_round(mid.ptx);
        d_by_next = q_round(mid.pty);
        d_cs_next = q_round(mid.psr);
    end

    always_comb
    begin
        e_df_next  = q_sat(q_x(q_round(d_pf_reg)) - q_x(d_fin_reg));
        e_dg_next  = q_sat(q_x(q_round(d_pg_reg)) - q_x(d_gin_reg));
        e_pax_next = prod_t'(d_ax_reg) * prod_t'(d_fx_reg);
        e_pby_next = prod_t'(d_by_reg) * prod_t'(d_fy_reg);
        e_pcq_next = prod_t'(d_cs_reg) * prod_t'(d_qs_reg);
    end

    always_comb
    begin
        f_pfd_next = prod_t'(e_df_reg) * prod_t'({1'b0, cfg.inv_tau_flow});
        f_phd_next = prod_t'(e_dg_reg) * prod_t'({1'b0, cfg.inv_tau_heat});
        f_frc_next = q_sat(q_x(q_round(e_pax_reg)) + q_x(q_round(e_pby_reg)));
        f_src_next = q_round(e_pcq_reg);
    end

    always_comb
    begin
        out_next.flow_out = q_sat(q_x(f_fin_reg) + q_x(q_round(f_pfd_reg)) + q_x(f_frc_reg));
        out_next.heat_out = q_sat(q_x(f_gin_reg) + q_x(q_round(f_phd_reg)) + q_x(f_src_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg   <= 1'b0;
            e_vld_reg   <= 1'b0;
            f_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            d_vld_reg   <= mid_vld;
            e_vld_reg   <= d_vld_reg;
            f_vld_reg   <= e_vld_reg;
            out_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        d_pf_reg  <= d_pf_next;
        d_pg_reg  <= d_pg_next;
        d_ax_reg  <= d_ax_next;
        d_by_reg  <= d_by_next;
        d_cs_reg  <= d_cs_next;
        d_fin_reg <= mid.fin;
        d_gin_reg <= mid.gin;
        d_fx_reg  <= mid.fx;
        d_fy_reg  <= mid.fy;
        d_qs_reg  <= mid.qs;

        e_df_reg  <= e_df_next;
        e_dg_reg  <= e_dg_next;
        e_pax_reg <= e_pax_next;
        e_pby_reg <= e_pby_next;
        e_pcq_reg <= e_pcq_next;
        e_fin_reg <= d_fin_reg;
        e_gin_reg <= d_gin_reg;

        f_pfd_reg <= f_pfd_next;
        f_phd_reg <= f_phd_next;
        f_frc_reg <= f_frc_next;
        f_src_reg <= f_src_next;
        f_fin_reg <= e_fin_reg;
        f_gin_reg <= e_gin_reg;

        out_reg   <= out_next;
    end

    assign done   = out_vld_reg;
    assign result = out_reg;

endmodule

`default_nettype wire

FILE: sv/lbm_d2q9_thermal_bgk_collision.sv
// a start beat passes stages a to f and the output register, then shows on result with done
// throughput: one beat per cycle; seven register stages, each with at most one multiplier deep
// busy is tied low, the pipeline never stalls and done is a one-cycle strobe
// reset: rst_n clears all stage valid bits and loads the register reset values
// top level: config registers, moment stages, relaxation stages
// depends on lbmtc_pkg, lbmtc_cfg_regs, lbmtc_front, lbmtc_back and the assertion macro header
`default_nettype none
`include "lbm_d2q9_thermal_bgk_collision_assert.svh"

module lbm_d2q9_thermal_bgk_collision import lbmtc_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire lbmtc_in_t     operands,
    output logic               done,
    output lbmtc_out_t         result,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [IW-1:0] cfg_index,
    input  wire q_t            cfg_data
);

    lbmtc_cfg_t cfg;
    lbmtc_mid_t mid;
    logic       mid_vld;
    logic       in_vld;

    assign busy   = 1'b0;
    assign in_vld = start && !busy;

    lbmtc_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lbmtc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (in_vld),
        .operands (operands),
        .cfg      (cfg),
        .mid_vld  (mid_vld),
        .mid      (mid)
    );

    lbmtc_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .mid_vld (mid_vld),
        .mid     (mid),
        .cfg     (cfg),
        .done    (done),
        .result  (result)
    );

    `LBMTC_ASSERT_IMP(a_done_has_beat, done, $past(start && !busy, 7), "result without a matching input beat")

endmodule

`default_nettype wire
